### src/chrt_pkg.sv
// ----------------------------------------------------------------------------
// Change range table package
// Shared constants, the entry record and the cell command for the table.
// ----------------------------------------------------------------------------
`default_nettype none

package chrt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int POS_BITS    = 16;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;

    localparam pos_t POS_MAX = '1;

    // Request kinds
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_INS   = 2'd1;
    localparam logic [1:0] KIND_ERASE = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    // Change types
    localparam logic [1:0] TYPE_NONE = 2'd0;
    localparam logic [1:0] TYPE_DEL  = 2'd1;
    localparam logic [1:0] TYPE_BAD  = 2'd3;

    // Cell operations
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_INS  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_WR   = 3'd3;
    localparam logic [2:0] OP_SHUP = 3'd4;
    localparam logic [2:0] OP_SHDN = 3'd5;

    typedef struct packed {
        pos_t        rng_start;
        pos_t        rng_end;
        logic [1:0]  ctype;
        logic [9:0]  author;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [2:0]        op;
        logic [ADDR_W-1:0] addr;
        pos_t              pos;
        entry_t            rec;
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/chrt_cell.sv
// ----------------------------------------------------------------------------
// Change range table cell
// Holds one range entry; shifts to or from its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module chrt_cell (
    input  wire                         clk,
    input  wire  [chrt_pkg::ADDR_W-1:0] cell_idx,
    input  chrt_pkg::cell_cmd_t         cmd,
    input  chrt_pkg::entry_t            left_ent,
    input  chrt_pkg::entry_t            right_ent,
    output chrt_pkg::entry_t            ent,
    output logic                        sat
);
    import chrt_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_INS:
            begin
                if (cell_idx > cmd.addr)
                begin
                    ent_next = left_ent;
                end
                else if (cell_idx == cmd.addr)
                begin
                    ent_next = cmd.rec;
                end
            end
            OP_DEL:
            begin
                if (cell_idx >= cmd.addr)
                begin
                    ent_next = right_ent;
                end
            end
            OP_WR:
            begin
                if (cell_idx == cmd.addr)
                begin
                    ent_next = cmd.rec;
                end
            end
            OP_SHUP:
            begin
                if (ent_reg.rng_start >= cmd.pos && ent_reg.rng_start != POS_MAX)
                begin
                    ent_next.rng_start = ent_reg.rng_start + 1'b1;
                end
                if (ent_reg.rng_end > cmd.pos && ent_reg.rng_end != POS_MAX)
                begin
                    ent_next.rng_end = ent_reg.rng_end + 1'b1;
                end
            end
            OP_SHDN:
            begin
                if (ent_reg.rng_start > cmd.pos)
                begin
                    ent_next.rng_start = ent_reg.rng_start - 1'b1;
                end
                if (ent_reg.rng_end > cmd.pos)
                begin
                    ent_next.rng_end = ent_reg.rng_end - 1'b1;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // A position already at the top cannot move up any further.
    assign sat = (cmd.op == OP_SHUP) &&
                 ((ent_reg.rng_start >= cmd.pos && ent_reg.rng_start == POS_MAX) ||
                  (ent_reg.rng_end > cmd.pos && ent_reg.rng_end == POS_MAX));

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;

endmodule

`default_nettype wire

### src/change_range_table_top.sv
// ----------------------------------------------------------------------------
// Change range table
// Sorted table of tracked-change ranges held in a row of cells.
// ----------------------------------------------------------------------------
// One request is worked at a time. The sequencer steps an index over the row
// of cells, one cell per cycle unless a cut tail is inserted, while inserts
// and removals shift the whole row by one cell at once. A query is one scan
// that gathers the result flags; an erase shifts the row down, then runs the
// merge scan and the flag scan. A set walks the table once, inserting each
// cut tail, then the merge scan runs, and a last scan gathers the result
// flags; an insert shifts the row up first. Every dropped or joined range
// restarts the merge scan at the first cell. The result sits in an output
// register, so the next request is taken while it waits.
`default_nettype none

module change_range_table_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    // span_start[15:0], span_end[31:16], change_type[33:32],
    // author_id[43:34], change_time[75:44], zero fill [79:76]
    input  wire  [79:0] s_tdata,
    // kind[1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // found_type[1:0], found_author[11:2], found_time[43:12],
    // span_overlaps[44], span_deleted[45], any_changed[46], table_overflow[47]
    output logic [47:0] m_tdata
);
    import chrt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SHIFT = 4'd1;
    localparam logic [3:0] S_A     = 4'd2;
    localparam logic [3:0] S_ATAIL = 4'd3;
    localparam logic [3:0] S_B     = 4'd4;
    localparam logic [3:0] S_C     = 4'd5;
    localparam logic [3:0] S_M     = 4'd6;
    localparam logic [3:0] S_MJ    = 4'd7;
    localparam logic [3:0] S_F     = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    entry_t              cell_ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] sat_vec;
    logic [TABLE_DEPTH-1:0] live;
    cell_cmd_t           cmd;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [1:0]       kind_reg, kind_next;
    pos_t             s_reg, s_next;
    pos_t             e_reg, e_next;
    logic [1:0]       type_reg, type_next;
    logic [9:0]       author_reg, author_next;
    logic [31:0]      time_reg, time_next;
    entry_t           tail_reg, tail_next;
    logic             ovf_reg, ovf_next;
    logic             found_reg, found_next;
    logic [1:0]       ftype_reg, ftype_next;
    logic [9:0]       fauthor_reg, fauthor_next;
    logic [31:0]      ftime_reg, ftime_next;
    logic             ovl_reg, ovl_next;
    logic             delf_reg, delf_next;
    logic             del_reg, del_next;
    logic             anyc_reg, anyc_next;
    logic             out_valid_reg, out_valid_next;
    logic [47:0]      out_data_reg, out_data_next;

    entry_t           cur;
    entry_t           nxt;
    entry_t           wr_rec;
    logic             at_end;
    logic             last;
    logic             has_room;
    logic             similar;
    pos_t             in_start;
    logic [1:0]       in_type;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            entry_t left_ent;
            entry_t right_ent;
            if (g == 0)
            begin : g_first
                assign left_ent = cell_ent[g];
            end
            else
            begin : g_inner_l
                assign left_ent = cell_ent[g-1];
            end
            if (g == TABLE_DEPTH - 1)
            begin : g_last
                assign right_ent = cell_ent[g];
            end
            else
            begin : g_inner_r
                assign right_ent = cell_ent[g+1];
            end
            chrt_cell u_cell (
                .clk       (clk),
                .cell_idx  (ADDR_W'(g)),
                .cmd       (cmd),
                .left_ent  (left_ent),
                .right_ent (right_ent),
                .ent       (cell_ent[g]),
                .sat       (sat_vec[g])
            );
        end
    endgenerate

    always_comb
    begin
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            live[k] = (IDX_W'(k) < count_reg);
        end
    end

    assign cur      = cell_ent[idx_reg[ADDR_W-1:0]];
    assign nxt      = cell_ent[ADDR_W'(idx_reg + 1'b1)];
    assign at_end   = (idx_reg >= count_reg);
    assign last     = ((IDX_W + 1)'(idx_reg) + 1'b1) >= (IDX_W + 1)'(count_reg);
    assign has_room = (count_reg < IDX_W'(TABLE_DEPTH));
    assign similar  = (cur.ctype == nxt.ctype) &&
                      (cur.ctype == TYPE_NONE || cur.author == nxt.author);
    assign in_start = POS_BITS'(s_tdata[15:0]);
    assign in_type  = (s_tdata[33:32] == TYPE_BAD) ? TYPE_NONE : s_tdata[33:32];

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        s_next         = s_reg;
        e_next         = e_reg;
        type_next      = type_reg;
        author_next    = author_reg;
        time_next      = time_reg;
        tail_next      = tail_reg;
        ovf_next       = ovf_reg;
        found_next     = found_reg;
        ftype_next     = ftype_reg;
        fauthor_next   = fauthor_reg;
        ftime_next     = ftime_reg;
        ovl_next       = ovl_reg;
        delf_next      = delf_reg;
        del_next       = del_reg;
        anyc_next      = anyc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_rec         = cur;
        cmd.op         = OP_NONE;
        cmd.addr       = idx_reg[ADDR_W-1:0];
        cmd.pos        = s_reg;
        cmd.rec        = cur;

        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    kind_next    = s_tuser;
                    s_next       = in_start;
                    e_next       = POS_BITS'(s_tdata[31:16]);
                    type_next    = in_type;
                    author_next  = s_tdata[43:34];
                    time_next    = s_tdata[75:44];
                    idx_next     = '0;
                    ovf_next     = 1'b0;
                    found_next   = 1'b0;
                    ftype_next   = TYPE_NONE;
                    fauthor_next = '0;
                    ftime_next   = '0;
                    ovl_next     = 1'b0;
                    delf_next    = 1'b0;
                    del_next     = 1'b0;
                    anyc_next    = 1'b0;
                    case (s_tuser)
                        KIND_SET:
                        begin
                            state_next = S_A;
                        end
                        KIND_INS:
                        begin
                            state_next = S_SHIFT;
                            if (in_start == POS_MAX)
                            begin
                                e_next   = POS_MAX;
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                e_next = in_start + 1'b1;
                            end
                        end
                        KIND_ERASE:
                        begin
                            state_next = S_SHIFT;
                        end
                        default:
                        begin
                            state_next = S_F;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (kind_reg == KIND_INS)
                begin
                    cmd.op     = OP_SHUP;
                    ovf_next   = ovf_reg | (|(sat_vec & live));
                    state_next = S_A;
                end
                else
                begin
                    cmd.op     = OP_SHDN;
                    state_next = S_M;
                end
                idx_next = '0;
            end
            S_A:
            begin
                if (at_end || cur.rng_start >= s_reg)
                begin
                    state_next = S_B;
                end
                else if (cur.rng_end > s_reg)
                begin
                    // Cut the range at the span start; keep what lies past the span.
                    wr_rec.rng_end = s_reg;
                    cmd.op         = OP_WR;
                    cmd.rec        = wr_rec;
                    idx_next       = idx_reg + 1'b1;
                    if (cur.rng_end >= e_reg)
                    begin
                        tail_next           = cur;
                        tail_next.rng_start = e_reg;
                        state_next          = S_ATAIL;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ATAIL:
            begin
                if (has_room)
                begin
                    cmd.op     = OP_INS;
                    cmd.rec    = tail_reg;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
                state_next = S_A;
            end
            S_B:
            begin
                if (type_reg != TYPE_NONE)
                begin
                    if (has_room)
                    begin
                        cmd.op               = OP_INS;
                        cmd.rec.rng_start    = s_reg;
                        cmd.rec.rng_end      = e_reg;
                        cmd.rec.ctype        = type_reg;
                        cmd.rec.author       = author_reg;
                        cmd.rec.stamp        = time_reg;
                        count_next           = count_reg + 1'b1;
                        idx_next             = idx_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                state_next = S_C;
            end
            S_C:
            begin
                if (at_end)
                begin
                    state_next = S_M;
                    idx_next   = '0;
                end
                else if (cur.rng_start >= s_reg && cur.rng_end <= e_reg)
                begin
                    cmd.op     = OP_DEL;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    if (cur.rng_start < e_reg)
                    begin
                        wr_rec.rng_start = e_reg;
                        cmd.op           = OP_WR;
                        cmd.rec          = wr_rec;
                    end
                    state_next = S_M;
                    idx_next   = '0;
                end
            end
            S_M:
            begin
                if (at_end)
                begin
                    state_next = S_F;
                    idx_next   = '0;
                end
                else if (cur.rng_start == cur.rng_end)
                begin
                    cmd.op     = OP_DEL;
                    count_next = count_reg - 1'b1;
                    idx_next   = '0;
                end
                else if (last)
                begin
                    state_next = S_F;
                    idx_next   = '0;
                end
                else if (similar && cur.rng_end == nxt.rng_start)
                begin
                    // The right-hand range absorbs the left one, then the left is dropped.
                    wr_rec           = nxt;
                    wr_rec.rng_start = cur.rng_start;
                    if (cur.stamp > nxt.stamp)
                    begin
                        wr_rec.stamp = cur.stamp;
                    end
                    cmd.op     = OP_WR;
                    cmd.addr   = ADDR_W'(idx_reg + 1'b1);
                    cmd.rec    = wr_rec;
                    state_next = S_MJ;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_MJ:
            begin
                cmd.op     = OP_DEL;
                count_next = count_reg - 1'b1;
                idx_next   = '0;
                state_next = S_M;
            end
            S_F:
            begin
                if (at_end)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (cur.ctype != TYPE_NONE)
                    begin
                        anyc_next = 1'b1;
                    end
                    if (kind_reg == KIND_QUERY)
                    begin
                        if (!found_reg && s_reg >= cur.rng_start && s_reg < cur.rng_end)
                        begin
                            found_next   = 1'b1;
                            ftype_next   = cur.ctype;
                            fauthor_next = cur.author;
                            ftime_next   = cur.stamp;
                        end
                        if (s_reg < cur.rng_end && e_reg > cur.rng_start)
                        begin
                            ovl_next = 1'b1;
                        end
                        if (!delf_reg && s_reg >= cur.rng_start && e_reg <= cur.rng_end)
                        begin
                            delf_next = 1'b1;
                            del_next  = (cur.ctype == TYPE_DEL);
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {ovf_reg, anyc_reg, del_reg, ovl_reg,
                                      ftime_reg, fauthor_reg, ftype_reg};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        kind_reg     <= kind_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        type_reg     <= type_next;
        author_reg   <= author_next;
        time_reg     <= time_next;
        tail_reg     <= tail_next;
        ovf_reg      <= ovf_next;
        found_reg    <= found_next;
        ftype_reg    <= ftype_next;
        fauthor_reg  <= fauthor_next;
        ftime_reg    <= ftime_next;
        ovl_reg      <= ovl_next;
        delf_reg     <= delf_next;
        del_reg      <= del_next;
        anyc_reg     <= anyc_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### src/chrt_checker.sv
// ----------------------------------------------------------------------------
// Change range table checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module chrt_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata
);

    // A result that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Stored ranges always carry a type, so an empty hit has no author or time.
    a_empty_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[43:2] == '0)
        else $error("found fields set without a found type");

    // Query results never flag overflow, and change results never report a hit.
    a_kind_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[47] |-> m_tdata[1:0] == 2'd0 && !m_tdata[44] && !m_tdata[45])
        else $error("overflow reported together with query fields");

    // An empty table cannot overlap or hold anything.
    a_empty_tab: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[46] |-> m_tdata[1:0] == 2'd0 && !m_tdata[44] && !m_tdata[45])
        else $error("query hit on a table without changes");

endmodule

bind change_range_table_top chrt_checker u_chrt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### sim/tb.sv
// ----------------------------------------------------------------------------
// Change range table testbench
// Drives set, insert, erase and query requests into the table over the stream
// ports. A local copy of the range table predicts every result, and each
// result is checked field by field against that prediction in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import chrt_pkg::*;

    localparam logic [1:0] TYPE_INSERTED = 2'd2;
    localparam int         STALL_LIMIT   = 20000;

    typedef struct packed {
        logic        ovf;
        logic        any_chg;
        logic        deleted;
        logic        overlaps;
        logic [31:0] stamp;
        logic [9:0]  author;
        logic [1:0]  ctype;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    change_range_table_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Local copy of the range table.
    entry_t      ranges [TABLE_DEPTH];
    int          range_count;
    bit          shift_ovf;

    result_t     pending_results [$];
    int          error_count;
    bit          idle_on;
    int          quiet_cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic pos_t bump_pos(pos_t p);
        if (p >= POS_MAX)
        begin
            shift_ovf = 1'b1;
            return POS_MAX;
        end
        return p + 1'b1;
    endfunction

    function automatic bit put_range(int at, entry_t r);
        if (range_count >= TABLE_DEPTH || at > range_count)
        begin
            shift_ovf = 1'b1;
            return 1'b0;
        end
        for (int k = range_count; k > at; k--)
            ranges[k] = ranges[k-1];
        ranges[at] = r;
        range_count++;
        return 1'b1;
    endfunction

    function automatic void drop_range(int at);
        if (at >= range_count)
            return;
        for (int k = at; k < range_count - 1; k++)
            ranges[k] = ranges[k+1];
        range_count--;
    endfunction

    // Drops empty ranges and joins neighbors of the same type and author;
    // every change restarts the scan from the first entry.
    function automatic void compact_ranges();
        int  i;
        bit  alike;
        i = 0;
        while (i < range_count)
        begin
            if (ranges[i].rng_start == ranges[i].rng_end)
            begin
                drop_range(i);
                i = 0;
                continue;
            end
            if (i + 1 >= range_count)
                break;
            alike = (ranges[i].ctype == ranges[i+1].ctype) &&
                    (ranges[i].ctype == TYPE_NONE ||
                     ranges[i].author == ranges[i+1].author);
            if (alike && ranges[i].rng_end == ranges[i+1].rng_start)
            begin
                ranges[i+1].rng_start = ranges[i].rng_start;
                if (ranges[i].stamp > ranges[i+1].stamp)
                    ranges[i+1].stamp = ranges[i].stamp;
                drop_range(i);
                i = 0;
                continue;
            end
            i++;
        end
    endfunction

    function automatic void apply_span(pos_t s, pos_t e, logic [1:0] t,
                                       logic [9:0] a, logic [31:0] stamp);
        int     i;
        pos_t   old_end;
        entry_t r;
        i = 0;
        while (i < range_count)
        begin
            if (ranges[i].rng_start >= s)
                break;
            if (ranges[i].rng_end > s)
            begin
                old_end = ranges[i].rng_end;
                ranges[i].rng_end = s;
                i++;
                // The part of the old range past the span survives as a copy.
                if (old_end >= e)
                begin
                    r = ranges[i-1];
                    r.rng_start = e;
                    r.rng_end = old_end;
                    void'(put_range(i, r));
                end
                continue;
            end
            i++;
        end
        if (t != TYPE_NONE)
        begin
            r.rng_start = s;
            r.rng_end = e;
            r.ctype = t;
            r.author = a;
            r.stamp = stamp;
            if (put_range(i, r))
                i++;
        end
        while (i < range_count)
        begin
            if (ranges[i].rng_start >= s && ranges[i].rng_end <= e)
            begin
                drop_range(i);
                continue;
            end
            if (ranges[i].rng_start >= e)
                break;
            ranges[i].rng_start = e;
            break;
        end
        compact_ranges();
    endfunction

    function automatic result_t apply_request(logic [1:0] kind, pos_t s, pos_t e,
                                              logic [1:0] t, logic [9:0] a,
                                              logic [31:0] stamp);
        result_t res;
        res = '0;
        shift_ovf = 1'b0;
        if (t == TYPE_BAD)
            t = TYPE_NONE;
        case (kind)
            KIND_SET:
                apply_span(s, e, t, a, stamp);
            KIND_INS:
            begin
                for (int k = 0; k < range_count; k++)
                begin
                    if (ranges[k].rng_start >= s)
                        ranges[k].rng_start = bump_pos(ranges[k].rng_start);
                    if (ranges[k].rng_end > s)
                        ranges[k].rng_end = bump_pos(ranges[k].rng_end);
                end
                apply_span(s, bump_pos(s), t, a, stamp);
            end
            KIND_ERASE:
            begin
                for (int k = 0; k < range_count; k++)
                begin
                    if (ranges[k].rng_start > s)
                        ranges[k].rng_start--;
                    if (ranges[k].rng_end > s)
                        ranges[k].rng_end--;
                end
                compact_ranges();
            end
            default:
            begin
                for (int k = 0; k < range_count; k++)
                    if (s >= ranges[k].rng_start && s < ranges[k].rng_end)
                    begin
                        res.ctype = ranges[k].ctype;
                        res.author = ranges[k].author;
                        res.stamp = ranges[k].stamp;
                        break;
                    end
                for (int k = 0; k < range_count; k++)
                    if (s < ranges[k].rng_end && e > ranges[k].rng_start)
                    begin
                        res.overlaps = 1'b1;
                        break;
                    end
                for (int k = 0; k < range_count; k++)
                    if (s >= ranges[k].rng_start && e <= ranges[k].rng_end)
                    begin
                        res.deleted = (ranges[k].ctype == TYPE_DEL);
                        break;
                    end
            end
        endcase
        for (int k = 0; k < range_count; k++)
            if (ranges[k].ctype != TYPE_NONE)
            begin
                res.any_chg = 1'b1;
                break;
            end
        res.ovf = (kind != KIND_QUERY) && shift_ovf;
        return res;
    endfunction

    // Appends one predicted result to the end of the pending list.
    function automatic void queue_result(result_t r);
        pending_results = {pending_results, r};
    endfunction

    // Sends one request, at times after a random gap while idling is on.
    task automatic send_request(logic [1:0] kind, pos_t s, pos_t e, logic [1:0] t,
                                logic [9:0] a, logic [31:0] stamp);
        int gap;
        if (idle_on && ($urandom % 4 == 0))
        begin
            gap = $urandom_range(1, 11);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, stamp, a, t, e, s};
        do
            @(posedge clk);
        while (!s_tready);
        queue_result(apply_request(kind, s, e, t, a, stamp));
    endtask

    task automatic release_input();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // Result receiver: ready drops in random bursts while idling is on.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && ($urandom % 5 == 0))
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11) - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.ctype !== want.ctype)
                begin
                    $display("%0t: found_type expected %0d actual %0d",
                             $realtime, want.ctype, got.ctype);
                    error_count++;
                end
                if (got.author !== want.author)
                begin
                    $display("%0t: found_author expected %0d actual %0d",
                             $realtime, want.author, got.author);
                    error_count++;
                end
                if (got.stamp !== want.stamp)
                begin
                    $display("%0t: found_time expected %h actual %h",
                             $realtime, want.stamp, got.stamp);
                    error_count++;
                end
                if (got.overlaps !== want.overlaps)
                begin
                    $display("%0t: span_overlaps expected %b actual %b",
                             $realtime, want.overlaps, got.overlaps);
                    error_count++;
                end
                if (got.deleted !== want.deleted)
                begin
                    $display("%0t: span_deleted expected %b actual %b",
                             $realtime, want.deleted, got.deleted);
                    error_count++;
                end
                if (got.any_chg !== want.any_chg)
                begin
                    $display("%0t: any_changed expected %b actual %b",
                             $realtime, want.any_chg, got.any_chg);
                    error_count++;
                end
                if (got.ovf !== want.ovf)
                begin
                    $display("%0t: table_overflow expected %b actual %b",
                             $realtime, want.ovf, got.ovf);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves a request.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(KIND_QUERY, 16'd0, 16'd10, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_SET, 16'd10, 16'd20, TYPE_DEL, 10'd1, 32'd100);
        send_request(KIND_SET, 16'd20, 16'd30, TYPE_DEL, 10'd1, 32'd50);
        send_request(KIND_SET, 16'd30, 16'd40, TYPE_INSERTED, 10'h3FF, 32'hFFFF_FFFF);
        send_request(KIND_QUERY, 16'd15, 16'd25, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_QUERY, 16'd35, 16'd38, TYPE_NONE, 10'd0, 32'd0);
        // A span inside an existing range splits it in two.
        send_request(KIND_SET, 16'd12, 16'd14, TYPE_INSERTED, 10'd2, 32'd7);
        send_request(KIND_QUERY, 16'd13, 16'd13, TYPE_NONE, 10'd0, 32'd0);
        // Type code three only clears.
        send_request(KIND_SET, 16'd25, 16'd33, TYPE_BAD, 10'd5, 32'd9);
        send_request(KIND_QUERY, 16'd26, 16'd27, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_SET, 16'd45, 16'd42, TYPE_DEL, 10'd3, 32'd11);
        send_request(KIND_QUERY, 16'd42, 16'd45, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_INS, 16'd0, 16'd0, TYPE_INSERTED, 10'd4, 32'd12);
        send_request(KIND_INS, 16'd11, 16'd0, TYPE_DEL, 10'd1, 32'd13);
        send_request(KIND_ERASE, 16'd5, 16'd0, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_ERASE, 16'd0, 16'd0, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_QUERY, 16'd10, 16'd40, TYPE_NONE, 10'd0, 32'd0);
        // Near the top position shifts saturate.
        send_request(KIND_SET, 16'hFFF0, 16'hFFFF, TYPE_DEL, 10'd6, 32'd14);
        send_request(KIND_INS, 16'hFFF8, 16'd0, TYPE_INSERTED, 10'd6, 32'd15);
        send_request(KIND_INS, 16'hFFFF, 16'd0, TYPE_DEL, 10'd6, 32'd16);
        send_request(KIND_QUERY, 16'hFFFE, 16'hFFFF, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_SET, 16'd0, 16'hFFFF, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_QUERY, 16'd0, 16'hFFFF, TYPE_NONE, 10'd0, 32'd0);
    endtask

    // Fills the table with single-position ranges of alternating authors.
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
            send_request(KIND_INS, 16'd100, 16'd0, TYPE_INSERTED, 10'(k % 2), 32'(k));
        send_request(KIND_QUERY, 16'd110, 16'd120, TYPE_NONE, 10'd0, 32'd0);
        send_request(KIND_SET, 16'd0, 16'hFFFF, TYPE_NONE, 10'd0, 32'd0);
    endtask

    task automatic test_random(int count);
        logic [1:0] kind;
        pos_t       s;
        pos_t       e;
        logic [1:0] t;
        logic [9:0] a;
        for (int n = 0; n < count; n++)
        begin
            if (n == count - 150)
                idle_on = 1'b0;
            kind = 2'($urandom_range(0, 3));
            if ($urandom % 10 == 0)
            begin
                s = 16'($urandom);
                e = 16'($urandom);
            end
            else
            begin
                s = 16'($urandom_range(0, 300));
                e = ($urandom % 12 == 0) ? s - 16'($urandom_range(1, 5))
                                         : s + 16'($urandom_range(0, 40));
            end
            t = 2'($urandom_range(0, 3));
            a = ($urandom % 8 == 0) ? 10'($urandom) : 10'($urandom_range(0, 2));
            // Clear now and then so the table does not stay full.
            if ($urandom % 60 == 0)
                send_request(KIND_SET, 16'd0, 16'hFFFF, TYPE_NONE, a, $urandom);
            else
                send_request(kind, s, e, t, a, $urandom);
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        range_count = 0;
        error_count = 0;
        quiet_cycles = 0;
        idle_on     = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_full_table();
        test_random(850);
        release_input();

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (300) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/chrt_pkg.sv
src/chrt_cell.sv
src/change_range_table_top.sv
src/chrt_checker.sv
sim/tb.sv
